[hdl/pcm_pkg.sv]
// ----------------------------------------------------------------------------
// pcm_pkg
// Shared types and constants for the pseudo-color mapper.
// ----------------------------------------------------------------------------
package pcm_pkg;

  // color map codes
  typedef enum logic {
    MAP_JET = 1'b0,
    MAP_HOT = 1'b1
  } map_t;

  // configuration register indexes
  localparam int unsigned REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_MAP_SELECT     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_RANGE_MIN      = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LEVEL_SCALE    = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_USE_BACKGROUND = 2'd3;

  // level range
  localparam int unsigned LEVEL_W = 10;
  localparam logic [LEVEL_W-1:0] JET_TOP = 10'd1019;
  localparam logic [LEVEL_W-1:0] HOT_TOP = 10'd638;

  // per-item flags that travel alongside the datapath
  typedef struct packed {
    logic       nan;
    logic       inf;
    logic [7:0] gray;
  } pcm_tag_t;

endpackage

[hdl/pcm_scale.sv]
// ----------------------------------------------------------------------------
// pcm_scale
// Product register for diff * level_scale, then round and clamp to a level.
// ----------------------------------------------------------------------------
module pcm_scale
  import pcm_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_pos,
  input  logic [31:0]        in_diff,
  input  logic [31:0]        scale,
  input  map_t               map_sel,
  output logic               out_valid,
  output logic [LEVEL_W-1:0] level
);

  localparam int unsigned SHIFT = 2 * FRAC_BITS;

  logic        valid;
  logic        pos;
  logic [63:0] prod;

  logic               upper_hit;
  logic [LEVEL_W:0]   rounded;
  logic [LEVEL_W-1:0] top;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    pos  <= in_pos;
    prod <= 64'(in_diff) * 64'(scale);
  end

  always_comb begin
    top       = (map_sel == MAP_HOT) ? HOT_TOP : JET_TOP;
    // anything above the low level bits saturates
    upper_hit = |prod[63:SHIFT+LEVEL_W];
    rounded   = {1'b0, prod[SHIFT+LEVEL_W-1:SHIFT]} + (LEVEL_W+1)'(prod[SHIFT-1]);
    if (!pos) begin
      level = '0;
    end else if (upper_hit || (rounded > {1'b0, top})) begin
      level = top;
    end else begin
      level = rounded[LEVEL_W-1:0];
    end
  end

  assign out_valid = valid;

endmodule

[hdl/pcm_color.sv]
// ----------------------------------------------------------------------------
// pcm_color
// Level to RGB through the jet / hot ramps, plus NaN and infinity colors.
// ----------------------------------------------------------------------------
module pcm_color
  import pcm_pkg::*;
(
  input  map_t               map_sel,
  input  logic               use_bg,
  input  pcm_tag_t           tag,
  input  logic [LEVEL_W-1:0] level,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue
);

  logic [7:0] gray;

  always_comb begin
    gray  = use_bg ? tag.gray : 8'd0;
    red   = 8'd0;
    green = 8'd0;
    blue  = 8'd0;
    priority if (tag.nan) begin
      if (map_sel == MAP_HOT) begin
        blue = 8'd255;
      end else begin
        red   = 8'd255;
        green = 8'd255;
        blue  = 8'd255;
      end
    end else if (tag.inf) begin
      red   = gray;
      green = gray;
      blue  = gray;
    end else if (map_sel == MAP_HOT) begin
      priority if (level < 10'd256) begin
        red = level[7:0];
      end else if (level < 10'd511) begin
        red   = 8'd255;
        green = 8'(level - 10'd255);
      end else begin
        red   = 8'd255;
        green = 8'd255;
        blue  = 8'({level - 10'd511, 1'b1});
      end
    end else begin
      priority if (level < 10'd128) begin
        blue = 8'(10'd128 + level);
      end else if (level < 10'd383) begin
        green = 8'(level - 10'd127);
        blue  = 8'd255;
      end else if (level < 10'd638) begin
        red   = 8'(level - 10'd382);
        green = 8'd255;
        blue  = 8'(10'd637 - level);
      end else if (level < 10'd893) begin
        red   = 8'd255;
        green = 8'(10'd892 - level);
      end else begin
        red = 8'(11'd1147 - {1'b0, level});
      end
    end
  end

endmodule

[hdl/pseudo_color_mapper.sv]
// ----------------------------------------------------------------------------
// pseudo_color_mapper
// Maps one signed fixed-point sample per clock to a jet or hot RGB pixel.
// ----------------------------------------------------------------------------
// One item is taken on every clock where start is high; busy is always low,
// so a new sample may follow without a gap. Each pixel appears on
// red/green/blue with done high for one cycle, in the order the items were
// taken. The receiver cannot stall, so it must take the pixel in that cycle.
// The pipeline has three register stages: the range subtract at the input,
// the 32x32 product of the difference and level_scale, and the round/clamp
// plus color ramps in front of the result register. Configuration writes
// (wr_en, wr_index, wr_data) take effect at the next edge and should only
// be made while no item is in flight. There is no memory and no clearing
// pass after reset.
// ----------------------------------------------------------------------------
module pseudo_color_mapper
  import pcm_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  // item input
  input  logic                 start,
  output logic                 busy,
  input  logic signed [31:0]   sample_value,
  input  logic                 is_nan,
  input  logic                 is_inf,
  input  logic [7:0]           gray_level,
  // configuration
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [31:0]          wr_data,
  // result
  output logic                 done,
  output logic [7:0]           red,
  output logic [7:0]           green,
  output logic [7:0]           blue
);

  // configuration registers
  map_t               map_select;
  logic signed [31:0] range_min;
  logic [31:0]        level_scale;
  logic               use_background;

  // stage 1: difference from range_min
  logic               accept;
  logic [32:0]        diff_next;
  logic               v1;
  logic               pos1;
  logic [31:0]        diff1;
  pcm_tag_t           tag1;

  // stage 2: product, then level
  logic               v2;
  pcm_tag_t           tag2;
  logic [LEVEL_W-1:0] level;

  logic [7:0]         red_next;
  logic [7:0]         green_next;
  logic [7:0]         blue_next;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      map_select     <= MAP_JET;
      range_min      <= '0;
      level_scale    <= 32'(64'd1 << FRAC_BITS);  // 1.0
      use_background <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MAP_SELECT:     map_select     <= map_t'(wr_data[0]);
        REG_RANGE_MIN:      range_min      <= wr_data;
        REG_LEVEL_SCALE:    level_scale    <= wr_data;
        REG_USE_BACKGROUND: use_background <= wr_data[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: 33-bit signed difference. A positive difference always fits in
  // 32 unsigned bits; zero or negative forces level 0 later on.
  // --------------------------------------------------------------------------
  assign diff_next = {sample_value[31], sample_value} - {range_min[31], range_min};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    pos1  <= !diff_next[32] && (|diff_next[31:0]);
    diff1 <= diff_next[31:0];
    tag1  <= '{nan: is_nan, inf: is_inf, gray: gray_level};
  end

  // --------------------------------------------------------------------------
  // Stage 2: product register, round half up, clamp to the map's top level
  // --------------------------------------------------------------------------
  pcm_scale #(
    .FRAC_BITS (FRAC_BITS)
  ) u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_pos    (pos1),
    .in_diff   (diff1),
    .scale     (level_scale),
    .map_sel   (map_select),
    .out_valid (v2),
    .level     (level)
  );

  always_ff @(posedge clk) begin
    tag2 <= tag1;
  end

  // --------------------------------------------------------------------------
  // Stage 3: color ramps and special colors into the result register
  // --------------------------------------------------------------------------
  pcm_color u_color (
    .map_sel (map_select),
    .use_bg  (use_background),
    .tag     (tag2),
    .level   (level),
    .red     (red_next),
    .green   (green_next),
    .blue    (blue_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v2;
    end
  end

  always_ff @(posedge clk) begin
    red   <= red_next;
    green <= green_next;
    blue  <= blue_next;
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // every pixel traces back to an item taken on start
  a_done_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 3))
    else $error("pixel without a matching item");

  // the clamp keeps the level inside the selected map
  a_level_in_map: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (level <= ((map_select == MAP_HOT) ? HOT_TOP : JET_TOP)))
    else $error("level beyond top of map");

  // NaN color has full blue in both maps
  a_nan_blue: assert property (@(posedge clk) disable iff (rst)
    (v2 && tag2.nan) |=> (done && (blue == 8'd255)))
    else $error("NaN item did not give full blue");

endmodule
